// File: sv/assert_macros.svh
// assertion macros used by the checker file
// both sample on the rising edge of clk; arst_n is the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define OSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define OSA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/osa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_pkg
// shared types, constants and helpers of the owned slot allocator
// ----------------------------------------------------------------------------
package osa_pkg;

	localparam int SLOTS_DEF = 256;

	// field widths
	localparam int ID_W     = 22;
	localparam int NUM_W    = 16;
	localparam int GRANT_W  = 8;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 3;

	// free map word geometry
	localparam int MAP_BITS = 64;
	localparam int MAP_BW   = 6;

	// register port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	// register index bit paddr[2]
	localparam logic REG_REGION_KEY = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_GOT_ANY  = 3'd0,
		ST_CLAIMED  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_TAKEN    = 3'd3,
		ST_RANGE    = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic owner_rd;
		logic owner_wr;
		logic map_rd;
		logic map_wr;
	} mem_cmd_t;

	typedef struct packed {
		logic busy;
		logic any_found;
	} map_stat_t;

	typedef struct packed {
		logic [ID_W-1:0]    reply_to;
		status_t            status;
		logic [GRANT_W-1:0] slot;
		logic [KEY_W-1:0]   key;
		logic               all_rel;
	} rsp_t;

	// lowest zero bit: {found, index}
	function automatic logic [MAP_BW:0] first_zero(input logic [MAP_BITS-1:0] v);
		logic [MAP_BW:0] r;
		r = '0;
		for (int i = MAP_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = {1'b1, MAP_BW'(i)};
			end
		end
		return r;
	endfunction

endpackage

// File: sv/osa_owner_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_owner_mem
// owner id per slot, one write and one registered read port
// ----------------------------------------------------------------------------
module osa_owner_mem #(
	parameter int DEPTH = osa_pkg::SLOTS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  osa_pkg::mem_cmd_t        cmd,
	input  logic [AW-1:0]            rd_addr,
	input  logic [AW-1:0]            wr_addr,
	input  logic [osa_pkg::ID_W-1:0] wr_data,
	output logic [osa_pkg::ID_W-1:0] rd_data
);

	logic [osa_pkg::ID_W-1:0] mem [DEPTH];
	logic [osa_pkg::ID_W-1:0] rd_data_q;

	// entries are only trusted where the free map marks them held
	always_ff @(posedge clk) begin
		if (cmd.owner_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.owner_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/osa_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_bitmap
// held-slot map in 64-bit words, word-full summary and clearing sweep
// ----------------------------------------------------------------------------
module osa_bitmap #(
	parameter int SLOTS = osa_pkg::SLOTS_DEF,
	localparam int WORDS = (SLOTS + osa_pkg::MAP_BITS - 1) / osa_pkg::MAP_BITS,
	localparam int WIDX = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  osa_pkg::mem_cmd_t            cmd,
	input  logic [WIDX-1:0]              rd_word,
	input  logic [WIDX-1:0]              wr_word,
	input  logic [osa_pkg::MAP_BITS-1:0] wr_data,
	output logic [osa_pkg::MAP_BITS-1:0] rd_data,
	output logic [WIDX-1:0]              any_word,
	output osa_pkg::map_stat_t           stat
);

	localparam int CLR_W = $clog2(WORDS + 1);
	localparam int REM = SLOTS - (WORDS - 1) * osa_pkg::MAP_BITS;
	// slots past the end of the table read as permanently held
	localparam logic [osa_pkg::MAP_BITS-1:0] LAST_PAD = (REM == osa_pkg::MAP_BITS) ? '0 :
		~((osa_pkg::MAP_BITS'(1) << REM) - osa_pkg::MAP_BITS'(1));

	logic [osa_pkg::MAP_BITS-1:0] mem [WORDS];
	logic [osa_pkg::MAP_BITS-1:0] rd_data_q;
	logic [WORDS-1:0]             full_q;
	logic                         busy_q;
	logic [CLR_W-1:0]             clr_q;
	logic                         clr_last;
	logic [osa_pkg::MAP_BITS-1:0] clr_data;
	logic                         w_en;
	logic [WIDX-1:0]              w_word;
	logic [osa_pkg::MAP_BITS-1:0] w_data;
	logic [osa_pkg::MAP_BITS-1:0] sum_pad;
	logic [osa_pkg::MAP_BW:0]     hit;

	assign clr_last = (32'(clr_q) == WORDS - 1);
	assign clr_data = clr_last ? LAST_PAD : '0;

	assign w_en   = busy_q | cmd.map_wr;
	assign w_word = busy_q ? clr_q[WIDX-1:0] : wr_word;
	assign w_data = busy_q ? clr_data : wr_data;

	always_ff @(posedge clk) begin
		if (w_en) begin
			mem[w_word] <= w_data;
		end
		if (cmd.map_rd) begin
			rd_data_q <= mem[rd_word];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
			full_q <= '0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + CLR_W'(1);
				if (clr_last) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.map_wr) begin
				full_q[wr_word] <= &wr_data;
			end
		end
	end

	// unused summary positions count as full
	assign sum_pad  = ~(osa_pkg::MAP_BITS'(~full_q));
	assign hit      = osa_pkg::first_zero(sum_pad);
	assign any_word = WIDX'(hit[osa_pkg::MAP_BW-1:0]);

	assign stat.busy      = busy_q;
	assign stat.any_found = hit[osa_pkg::MAP_BW];
	assign rd_data        = rd_data_q;

endmodule

// File: sv/osa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_ctrl
// request sequencer: early checks, map/owner read-modify-write, reply register
// ----------------------------------------------------------------------------
module osa_ctrl #(
	parameter int SLOTS = osa_pkg::SLOTS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int WORDS = (SLOTS + osa_pkg::MAP_BITS - 1) / osa_pkg::MAP_BITS,
	localparam int WIDX = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [osa_pkg::ID_W-1:0]      requester_id,
	input  logic                          want_any,
	input  logic [osa_pkg::NUM_W-1:0]     slot_number,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output osa_pkg::rsp_t                 rsp,
	input  logic [osa_pkg::KEY_W-1:0]     region_key,
	output osa_pkg::mem_cmd_t             cmd,
	output logic [SW-1:0]                 owner_rd_addr,
	output logic [SW-1:0]                 owner_wr_addr,
	output logic [osa_pkg::ID_W-1:0]      owner_wr_data,
	input  logic [osa_pkg::ID_W-1:0]      owner_rd_data,
	output logic [WIDX-1:0]               map_rd_word,
	output logic [WIDX-1:0]               map_wr_word,
	output logic [osa_pkg::MAP_BITS-1:0]  map_wr_data,
	input  logic [osa_pkg::MAP_BITS-1:0]  map_rd_data,
	input  logic [WIDX-1:0]               any_word,
	input  osa_pkg::map_stat_t            map_stat
);

	localparam int FW = WIDX + osa_pkg::MAP_BW;
	localparam int CW = $clog2(SLOTS + 1);

	osa_pkg::state_t  state_q, state_d;
	logic             acc, reject, out_free, load_out, load_pend;
	logic             in_look;
	logic [osa_pkg::ID_W-1:0] id_q;
	logic             any_q;
	logic [FW-1:0]    slot_q;
	logic [FW-1:0]    named_slot;
	logic [CW-1:0]    cnt_q, cnt_d, cnt_dec;
	osa_pkg::status_t early_st;
	osa_pkg::rsp_t    early_rsp, look_rsp, rsp_d, pend_q, rsp_q;
	logic             rsp_valid_q;
	logic [osa_pkg::MAP_BW:0]     free_hit;
	logic [FW-1:0]                look_slot;
	logic [osa_pkg::MAP_BITS-1:0] bit_mask;
	logic             held, own, do_set, do_clr;

	assign acc        = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign in_look    = (state_q == osa_pkg::S_LOOK);
	assign named_slot = FW'(slot_number[SW-1:0]);

	// checks that need no table access
	always_comb begin
		reject   = 1'b1;
		early_st = osa_pkg::ST_TAKEN;
		priority if (requester_id == '0) begin
			early_st = osa_pkg::ST_TAKEN;
		end else if (want_any) begin
			if (cnt_q == CW'(SLOTS) || !map_stat.any_found) begin
				early_st = osa_pkg::ST_FULL;
			end else begin
				reject = 1'b0;
			end
		end else if (32'(slot_number) >= SLOTS) begin
			early_st = osa_pkg::ST_RANGE;
		end else begin
			reject = 1'b0;
		end
	end

	always_comb begin
		early_rsp          = '0;
		early_rsp.reply_to = requester_id;
		early_rsp.status   = early_st;
	end

	// lookup stage, map word and owner are on the read ports
	assign free_hit  = osa_pkg::first_zero(map_rd_data);
	assign look_slot = any_q ? {slot_q[FW-1:osa_pkg::MAP_BW],
		free_hit[osa_pkg::MAP_BW-1:0]} : slot_q;
	assign bit_mask  = osa_pkg::MAP_BITS'(1) << look_slot[osa_pkg::MAP_BW-1:0];
	assign held      = |(map_rd_data & bit_mask);
	assign own       = held && (owner_rd_data == id_q);
	assign cnt_dec   = (cnt_q != '0) ? cnt_q - CW'(1) : '0;

	always_comb begin
		do_set            = 1'b0;
		do_clr            = 1'b0;
		cnt_d             = cnt_q;
		look_rsp          = '0;
		look_rsp.reply_to = id_q;
		look_rsp.status   = osa_pkg::ST_TAKEN;
		priority if (any_q) begin
			if (free_hit[osa_pkg::MAP_BW]) begin
				do_set          = 1'b1;
				cnt_d           = cnt_q + CW'(1);
				look_rsp.status = osa_pkg::ST_GOT_ANY;
				look_rsp.slot   = osa_pkg::GRANT_W'(look_slot);
				look_rsp.key    = region_key;
			end else begin
				look_rsp.status = osa_pkg::ST_FULL;
			end
		end else if (own) begin
			do_clr           = 1'b1;
			cnt_d            = cnt_dec;
			look_rsp.status  = osa_pkg::ST_RELEASED;
			look_rsp.slot    = osa_pkg::GRANT_W'(look_slot);
			look_rsp.all_rel = (cnt_dec == '0);
		end else if (!held) begin
			do_set          = 1'b1;
			cnt_d           = cnt_q + CW'(1);
			look_rsp.status = osa_pkg::ST_CLAIMED;
			look_rsp.slot   = osa_pkg::GRANT_W'(look_slot);
			look_rsp.key    = region_key;
		end else begin
			look_rsp.status = osa_pkg::ST_TAKEN;
		end
	end

	assign map_wr_data   = do_set ? (map_rd_data | bit_mask) : (map_rd_data & ~bit_mask);
	assign map_wr_word   = look_slot[FW-1:osa_pkg::MAP_BW];
	assign owner_wr_addr = look_slot[SW-1:0];
	assign owner_wr_data = id_q;
	assign map_rd_word   = want_any ? any_word : named_slot[FW-1:osa_pkg::MAP_BW];
	assign owner_rd_addr = slot_number[SW-1:0];

	always_comb begin
		unique case (state_q)
			osa_pkg::S_LOOK: rsp_d = look_rsp;
			osa_pkg::S_WAIT: rsp_d = pend_q;
			default:         rsp_d = early_rsp;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osa_pkg::S_CLEAR: begin
				if (!map_stat.busy) begin
					state_d = osa_pkg::S_IDLE;
				end
			end
			osa_pkg::S_IDLE: begin
				if (req_valid) begin
					if (!reject) begin
						state_d = osa_pkg::S_LOOK;
					end else if (!out_free) begin
						state_d = osa_pkg::S_WAIT;
					end
				end
			end
			osa_pkg::S_LOOK: begin
				state_d = out_free ? osa_pkg::S_IDLE : osa_pkg::S_WAIT;
			end
			osa_pkg::S_WAIT: begin
				if (out_free) begin
					state_d = osa_pkg::S_IDLE;
				end
			end
			default: state_d = osa_pkg::S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		req_stall    = 1'b1;
		cmd          = '0;
		load_out     = 1'b0;
		load_pend    = 1'b0;
		unique case (state_q)
			osa_pkg::S_CLEAR: begin
				req_stall = 1'b1;
			end
			osa_pkg::S_IDLE: begin
				req_stall    = 1'b0;
				cmd.map_rd   = req_valid && !reject;
				cmd.owner_rd = req_valid && !reject;
				load_out     = req_valid && reject && out_free;
				load_pend    = req_valid && reject && !out_free;
			end
			osa_pkg::S_LOOK: begin
				cmd.map_wr   = do_set || do_clr;
				cmd.owner_wr = do_set;
				load_out     = out_free;
				load_pend    = !out_free;
			end
			osa_pkg::S_WAIT: begin
				load_out = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= osa_pkg::S_CLEAR;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (in_look) begin
				cnt_q <= cnt_d;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			id_q   <= requester_id;
			any_q  <= want_any;
			slot_q <= want_any ? {any_word, osa_pkg::MAP_BW'(0)} : named_slot;
		end
		if (load_pend) begin
			pend_q <= rsp_d;
		end
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/owned_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owned_slot_allocator_top
// slot table with per-slot owner ids, any-slot and named claim/release
// ----------------------------------------------------------------------------
// Each request gets one reply. A request rejected on its fields alone (zero
// requester, table full, slot out of range) is answered without a table
// access. For any other, the accept cycle reads the free-map word and the
// owner entry; the lookup state then picks the lowest free bit for an any-slot
// request, writes the free map back (and the owner entry on a grant) and forms
// the reply. The next request is accepted once the sequencer is back in idle,
// after the read-then-write of the free-map memory. The reply sits in an output
// register, so a new request can go in while a reply still waits to be taken.
// After reset the free map is cleared word by word and requests stay stalled
// until the sequencer is idle; region_key can be written during that time.
// ----------------------------------------------------------------------------
module owned_slot_allocator_top #(
	parameter int SLOTS = osa_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [osa_pkg::ADDR_W-1:0]    paddr,
	input  logic [osa_pkg::DATA_W-1:0]    pwdata,
	output logic [osa_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [osa_pkg::ID_W-1:0]      requester_id,
	input  logic                          want_any,
	input  logic [osa_pkg::NUM_W-1:0]     slot_number,
	// reply channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [osa_pkg::ID_W-1:0]      reply_to,
	output logic [osa_pkg::STATUS_W-1:0]  status,
	output logic [osa_pkg::GRANT_W-1:0]   granted_slot,
	output logic [osa_pkg::KEY_W-1:0]     shared_key,
	output logic                          all_released
);

	localparam int SW = $clog2(SLOTS);
	localparam int WORDS = (SLOTS + osa_pkg::MAP_BITS - 1) / osa_pkg::MAP_BITS;
	localparam int WIDX = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [osa_pkg::KEY_W-1:0]    region_key_q;
	logic                         key_sel;
	logic                         cfg_wr;
	osa_pkg::mem_cmd_t            cmd;
	osa_pkg::map_stat_t           map_stat;
	osa_pkg::rsp_t                rsp;
	logic [SW-1:0]                owner_rd_addr, owner_wr_addr;
	logic [osa_pkg::ID_W-1:0]     owner_wr_data, owner_rd_data;
	logic [WIDX-1:0]              map_rd_word, map_wr_word, any_word;
	logic [osa_pkg::MAP_BITS-1:0] map_wr_data, map_rd_data;

	// register decode: the upper address bit selects the register, byte bits ignored
	assign key_sel = (paddr[osa_pkg::ADDR_W-1] == osa_pkg::REG_REGION_KEY);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = key_sel ? region_key_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_key_q <= '0;
		end else if (cfg_wr && key_sel) begin
			region_key_q <= pwdata;
		end
	end

	// sequencer: early checks, lookup and reply register
	osa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.requester_id  (requester_id),
		.want_any      (want_any),
		.slot_number   (slot_number),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.region_key    (region_key_q),
		.cmd           (cmd),
		.owner_rd_addr (owner_rd_addr),
		.owner_wr_addr (owner_wr_addr),
		.owner_wr_data (owner_wr_data),
		.owner_rd_data (owner_rd_data),
		.map_rd_word   (map_rd_word),
		.map_wr_word   (map_wr_word),
		.map_wr_data   (map_wr_data),
		.map_rd_data   (map_rd_data),
		.any_word      (any_word),
		.map_stat      (map_stat)
	);

	// owner ids, valid only where the free map marks a slot held
	osa_owner_mem #(.DEPTH(SLOTS)) u_owner (
		.clk     (clk),
		.cmd     (cmd),
		.rd_addr (owner_rd_addr),
		.wr_addr (owner_wr_addr),
		.wr_data (owner_wr_data),
		.rd_data (owner_rd_data)
	);

	// held-slot map with full-word summary for the any-slot search
	osa_bitmap #(.SLOTS(SLOTS)) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_word  (map_rd_word),
		.wr_word  (map_wr_word),
		.wr_data  (map_wr_data),
		.rd_data  (map_rd_data),
		.any_word (any_word),
		.stat     (map_stat)
	);

	// reply fields
	assign reply_to     = rsp.reply_to;
	assign status       = rsp.status;
	assign granted_slot = rsp.slot;
	assign shared_key   = rsp.key;
	assign all_released = rsp.all_rel;

endmodule

// File: sv/osa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_checker
// port-level checks on the reply channel of the slot allocator, plus req_stall in reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [osa_pkg::ID_W-1:0]      reply_to,
	input logic [osa_pkg::STATUS_W-1:0]  status,
	input logic [osa_pkg::GRANT_W-1:0]   granted_slot,
	input logic [osa_pkg::KEY_W-1:0]     shared_key,
	input logic                          all_released
);

	// a stalled reply transfer keeps its content
	`OSA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(reply_to) && $stable(status) && $stable(granted_slot) && $stable(shared_key) && $stable(all_released), "stalled reply changed")

	// key only goes out with a grant
	`OSA_ASSERT(a_key_grant, rsp_valid && status != osa_pkg::ST_GOT_ANY && status != osa_pkg::ST_CLAIMED |-> shared_key == '0, "key on a non-grant reply")

	// slot number only on grants and releases
	`OSA_ASSERT(a_slot_zero, rsp_valid && status != osa_pkg::ST_GOT_ANY && status != osa_pkg::ST_CLAIMED && status != osa_pkg::ST_RELEASED |-> granted_slot == '0, "slot on a rejected reply")

	// empty table is only reported by a release
	`OSA_ASSERT(a_all_rel, rsp_valid && all_released |-> status == osa_pkg::ST_RELEASED, "all_released without release")

	// nothing leaves while in reset
	`OSA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid && req_stall, "reply or accept during reset")

endmodule

bind owned_slot_allocator_top osa_checker u_osa_checker (.*);
